[rtl/albema_pkg.sv]
package albema_pkg;

   localparam int LUX_W = 20;
   localparam int BLOCK_LENGTH = 20;
   localparam int BLOCKS_PER_PERIOD = 5;
   localparam int QUEUE_DEPTH = 4;

   localparam int SHIFT_W = 4;
   localparam int LEVEL_W = 3;
   localparam int CSR_INDEX_W = 3;
   localparam int CSR_DATA_W = LUX_W;

   localparam int QPTR_W = $clog2(QUEUE_DEPTH);
   localparam int QCNT_W = $clog2(QUEUE_DEPTH + 1);

   localparam int SAMPLE_CNT_W = $clog2(BLOCK_LENGTH + 1);
   localparam int BLOCK_CNT_W = $clog2(BLOCKS_PER_PERIOD + 1);

   localparam int BLK_SH = $clog2(BLOCK_LENGTH);
   localparam int BLK_SUM_W = LUX_W + BLK_SH;
   localparam int BLK_RECIP_W = BLK_SUM_W + 1;
   localparam logic [BLK_RECIP_W-1:0] BLK_RECIP =
      BLK_RECIP_W'((64'd1 << (BLK_SUM_W + BLK_SH)) / BLOCK_LENGTH + 1);
   localparam int BLK_PROD_W = BLK_SUM_W + BLK_RECIP_W;

   localparam int PER_SH = $clog2(BLOCKS_PER_PERIOD);
   localparam int PER_SUM_W = LUX_W + PER_SH;
   localparam int PER_RECIP_W = PER_SUM_W + 1;
   localparam logic [PER_RECIP_W-1:0] PER_RECIP =
      PER_RECIP_W'((64'd1 << (PER_SUM_W + PER_SH)) / BLOCKS_PER_PERIOD + 1);
   localparam int PER_PROD_W = PER_SUM_W + PER_RECIP_W;

   localparam logic [LEVEL_W-1:0] LEVEL_0 = 3'd0;
   localparam logic [LEVEL_W-1:0] LEVEL_1 = 3'd1;
   localparam logic [LEVEL_W-1:0] LEVEL_2 = 3'd2;
   localparam logic [LEVEL_W-1:0] LEVEL_3 = 3'd3;
   localparam logic [LEVEL_W-1:0] LEVEL_4 = 3'd4;

   typedef enum logic [CSR_INDEX_W-1:0] {
      CSR_EMA_SHIFT        = 3'd0,
      CSR_THRESHOLD_LEVEL4 = 3'd1,
      CSR_THRESHOLD_LEVEL3 = 3'd2,
      CSR_THRESHOLD_LEVEL2 = 3'd3,
      CSR_THRESHOLD_LEVEL1 = 3'd4
   } csr_index_type;

   typedef struct packed {
      logic [SHIFT_W-1:0] ema_shift;
      logic [LUX_W-1:0]   threshold_level4;
      logic [LUX_W-1:0]   threshold_level3;
      logic [LUX_W-1:0]   threshold_level2;
      logic [LUX_W-1:0]   threshold_level1;
   } cfg_type;

   typedef struct packed {
      logic                 blk_done;
      logic [BLK_SUM_W-1:0] blk_sum;
   } front_beat_type;

endpackage

[rtl/albema_front.sv]
module albema_front (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              accept,
   input  logic [albema_pkg::LUX_W-1:0]      sample_lux,
   output albema_pkg::front_beat_type        beat
);

   logic [albema_pkg::BLK_SUM_W-1:0]    acc_ff, acc_in;
   logic [albema_pkg::SAMPLE_CNT_W-1:0] cnt_ff, cnt_in;
   logic [albema_pkg::BLK_SUM_W-1:0]    sum;
   logic                                done;

   always_comb begin
      sum = acc_ff + albema_pkg::BLK_SUM_W'(sample_lux);
      done = (cnt_ff == albema_pkg::SAMPLE_CNT_W'(albema_pkg::BLOCK_LENGTH - 1));
      beat.blk_done = done;
      beat.blk_sum = sum;
      acc_in = acc_ff;
      cnt_in = cnt_ff;
      if (accept) begin
         if (done) begin
            acc_in = '0;
            cnt_in = '0;
         end else begin
            acc_in = sum;
            cnt_in = cnt_ff + 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         acc_ff <= '0;
         cnt_ff <= '0;
      end else begin
         acc_ff <= acc_in;
         cnt_ff <= cnt_in;
      end
   end

endmodule

[rtl/albema_queue.sv]
module albema_queue (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       push,
   input  albema_pkg::front_beat_type push_beat,
   output logic                       full,
   input  logic                       pop,
   output logic                       empty,
   output albema_pkg::front_beat_type head_beat
);

   albema_pkg::front_beat_type slot_ff [albema_pkg::QUEUE_DEPTH];
   logic [albema_pkg::QPTR_W-1:0] wr_ptr_ff, wr_ptr_in;
   logic [albema_pkg::QPTR_W-1:0] rd_ptr_ff, rd_ptr_in;
   logic [albema_pkg::QCNT_W-1:0] count_ff, count_in;

   always_comb begin
      full = (count_ff == albema_pkg::QCNT_W'(albema_pkg::QUEUE_DEPTH));
      empty = (count_ff == '0);
      head_beat = slot_ff[rd_ptr_ff];
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in = count_ff;
      if (push) begin
         wr_ptr_in = (wr_ptr_ff == albema_pkg::QPTR_W'(albema_pkg::QUEUE_DEPTH - 1))
                     ? '0 : wr_ptr_ff + 1'b1;
      end
      if (pop) begin
         rd_ptr_in = (rd_ptr_ff == albema_pkg::QPTR_W'(albema_pkg::QUEUE_DEPTH - 1))
                     ? '0 : rd_ptr_ff + 1'b1;
      end
      if (push && !pop) begin
         count_in = count_ff + 1'b1;
      end else if (pop && !push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         slot_ff[wr_ptr_ff] <= push_beat;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff <= count_in;
      end
   end

endmodule

[rtl/albema_back.sv]
module albema_back (
   input  logic                             clock,
   input  logic                             reset,
   input  albema_pkg::cfg_type              cfg,
   input  logic                             q_empty,
   input  albema_pkg::front_beat_type       q_head,
   output logic                             q_pop,
   output logic                             rsp_valid,
   input  logic                             rsp_stall,
   output logic                             rsp_publish,
   output logic [albema_pkg::LUX_W-1:0]     rsp_smoothed_lux,
   output logic                             rsp_smoothed_valid,
   output logic [albema_pkg::LUX_W-1:0]     rsp_period_average,
   output logic [albema_pkg::LEVEL_W-1:0]   rsp_light_level
);

   logic advance;

   // Stage one: block average.
   logic [albema_pkg::BLK_PROD_W-1:0] blk_prod;
   logic                              s1_valid_ff, s1_valid_in;
   logic                              s1_done_ff;
   logic [albema_pkg::LUX_W-1:0]      s1_avg_ff;

   // Stage two: filter and period bookkeeping.
   logic [albema_pkg::LUX_W-1:0]       filter_ff, filter_in;
   logic                               loaded_ff, loaded_in;
   logic [albema_pkg::PER_SUM_W-1:0]   per_acc_ff, per_acc_in;
   logic [albema_pkg::BLOCK_CNT_W-1:0] blk_cnt_ff, blk_cnt_in;
   logic [albema_pkg::PER_SUM_W-1:0]   per_sum;
   logic                               per_done;
   logic [albema_pkg::LUX_W-1:0]       diff;
   logic [albema_pkg::LUX_W-1:0]       step;
   logic                               s2_valid_ff;
   logic                               s2_publish_ff, s2_publish_in;
   logic [albema_pkg::PER_SUM_W-1:0]   s2_per_sum_ff;
   logic [albema_pkg::LUX_W-1:0]       s2_filter_ff;
   logic                               s2_loaded_ff;

   // Output stage.
   logic [albema_pkg::PER_PROD_W-1:0] per_prod;
   logic [albema_pkg::LEVEL_W-1:0]    level;
   logic                              rsp_valid_ff;
   logic                              rsp_publish_ff;
   logic [albema_pkg::LUX_W-1:0]      rsp_smoothed_lux_ff;
   logic                              rsp_smoothed_valid_ff;
   logic [albema_pkg::LUX_W-1:0]      rsp_period_average_ff;
   logic [albema_pkg::LEVEL_W-1:0]    rsp_light_level_ff;

   assign advance = !rsp_valid_ff || !rsp_stall;
   assign q_pop = advance && !q_empty;
   assign s1_valid_in = q_pop;

   assign blk_prod = albema_pkg::BLK_PROD_W'(q_head.blk_sum)
                   * albema_pkg::BLK_PROD_W'(albema_pkg::BLK_RECIP);

   always_comb begin
      filter_in = filter_ff;
      loaded_in = loaded_ff;
      per_acc_in = per_acc_ff;
      blk_cnt_in = blk_cnt_ff;
      s2_publish_in = 1'b0;
      per_sum = per_acc_ff + albema_pkg::PER_SUM_W'(s1_avg_ff);
      per_done = (blk_cnt_ff == albema_pkg::BLOCK_CNT_W'(albema_pkg::BLOCKS_PER_PERIOD - 1));
      diff = '0;
      step = '0;
      if (s1_valid_ff && s1_done_ff) begin
         if (!loaded_ff) begin
            filter_in = s1_avg_ff;
            loaded_in = 1'b1;
         end else if (s1_avg_ff >= filter_ff) begin
            diff = s1_avg_ff - filter_ff;
            step = diff >> cfg.ema_shift;
            filter_in = filter_ff + step;
         end else begin
            // Arithmetic shift of a negative difference rounds toward minus infinity.
            diff = filter_ff - s1_avg_ff;
            step = ((diff - 1'b1) >> cfg.ema_shift) + 1'b1;
            filter_in = filter_ff - step;
         end
         if (per_done) begin
            per_acc_in = '0;
            blk_cnt_in = '0;
            s2_publish_in = 1'b1;
         end else begin
            per_acc_in = per_sum;
            blk_cnt_in = blk_cnt_ff + 1'b1;
         end
      end
   end

   assign per_prod = albema_pkg::PER_PROD_W'(s2_per_sum_ff)
                   * albema_pkg::PER_PROD_W'(albema_pkg::PER_RECIP);

   always_comb begin
      if (s2_filter_ff > cfg.threshold_level4) begin
         level = albema_pkg::LEVEL_4;
      end else if (s2_filter_ff > cfg.threshold_level3) begin
         level = albema_pkg::LEVEL_3;
      end else if (s2_filter_ff > cfg.threshold_level2) begin
         level = albema_pkg::LEVEL_2;
      end else if (s2_filter_ff > cfg.threshold_level1) begin
         level = albema_pkg::LEVEL_1;
      end else begin
         level = albema_pkg::LEVEL_0;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         s1_done_ff <= q_head.blk_done;
         s1_avg_ff <= blk_prod[albema_pkg::BLK_SUM_W + albema_pkg::BLK_SH +: albema_pkg::LUX_W];
         s2_publish_ff <= s2_publish_in;
         s2_per_sum_ff <= per_sum;
         s2_filter_ff <= filter_in;
         s2_loaded_ff <= loaded_in;
         rsp_publish_ff <= s2_publish_ff;
         rsp_smoothed_lux_ff <= s2_loaded_ff ? s2_filter_ff : '0;
         rsp_smoothed_valid_ff <= s2_loaded_ff;
         rsp_period_average_ff <= s2_publish_ff
            ? per_prod[albema_pkg::PER_SUM_W + albema_pkg::PER_SH +: albema_pkg::LUX_W]
            : '0;
         rsp_light_level_ff <= s2_loaded_ff ? level : albema_pkg::LEVEL_0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
         s2_valid_ff <= 1'b0;
         rsp_valid_ff <= 1'b0;
         filter_ff <= '0;
         loaded_ff <= 1'b0;
         per_acc_ff <= '0;
         blk_cnt_ff <= '0;
      end else if (advance) begin
         s1_valid_ff <= s1_valid_in;
         s2_valid_ff <= s1_valid_ff;
         rsp_valid_ff <= s2_valid_ff;
         filter_ff <= filter_in;
         loaded_ff <= loaded_in;
         per_acc_ff <= per_acc_in;
         blk_cnt_ff <= blk_cnt_in;
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_publish = rsp_publish_ff;
   assign rsp_smoothed_lux = rsp_smoothed_lux_ff;
   assign rsp_smoothed_valid = rsp_smoothed_valid_ff;
   assign rsp_period_average = rsp_period_average_ff;
   assign rsp_light_level = rsp_light_level_ff;

endmodule

[rtl/ambient_light_block_ema_smoother.sv]
// Channel   Direction  Handshake          Payload
// req_      in         req_valid/stall    sample_lux
// rsp_      out        rsp_valid/stall    publish, smoothed_lux, smoothed_valid,
//                                         period_average, light_level
// csr_      in         csr_write_enable   csr_index, csr_write_data
//
// One beat is accepted per cycle while req_stall is low; after its beat leaves the
// four-entry queue, each result passes the block divide, filter and output register stages.
// Reset is synchronous and clears counters, sums, the filter and the queue.
// A stalled result holds the back pipeline; the queue absorbs up to four beats
// before req_stall rises.
module ambient_light_block_ema_smoother (
   input  logic                                  clock,
   input  logic                                  reset,
   input  logic                                  req_valid,
   output logic                                  req_stall,
   input  logic [albema_pkg::LUX_W-1:0]          req_sample_lux,
   output logic                                  rsp_valid,
   input  logic                                  rsp_stall,
   output logic                                  rsp_publish,
   output logic [albema_pkg::LUX_W-1:0]          rsp_smoothed_lux,
   output logic                                  rsp_smoothed_valid,
   output logic [albema_pkg::LUX_W-1:0]          rsp_period_average,
   output logic [albema_pkg::LEVEL_W-1:0]        rsp_light_level,
   input  logic                                  csr_write_enable,
   input  logic [albema_pkg::CSR_INDEX_W-1:0]    csr_index,
   input  logic [albema_pkg::CSR_DATA_W-1:0]     csr_write_data
);

   albema_pkg::cfg_type        cfg_ff, cfg_in;
   albema_pkg::front_beat_type front_beat;
   albema_pkg::front_beat_type head_beat;
   logic                       q_full;
   logic                       q_empty;
   logic                       q_pop;
   logic                       accept;

   assign req_stall = q_full;
   assign accept = req_valid && !q_full;

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_write_enable) begin
         unique case (csr_index)
            albema_pkg::CSR_EMA_SHIFT:
               cfg_in.ema_shift = csr_write_data[albema_pkg::SHIFT_W-1:0];
            albema_pkg::CSR_THRESHOLD_LEVEL4:
               cfg_in.threshold_level4 = csr_write_data[albema_pkg::LUX_W-1:0];
            albema_pkg::CSR_THRESHOLD_LEVEL3:
               cfg_in.threshold_level3 = csr_write_data[albema_pkg::LUX_W-1:0];
            albema_pkg::CSR_THRESHOLD_LEVEL2:
               cfg_in.threshold_level2 = csr_write_data[albema_pkg::LUX_W-1:0];
            albema_pkg::CSR_THRESHOLD_LEVEL1:
               cfg_in.threshold_level1 = csr_write_data[albema_pkg::LUX_W-1:0];
            default: cfg_in = cfg_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.ema_shift <= albema_pkg::SHIFT_W'(1);
         cfg_ff.threshold_level4 <= albema_pkg::LUX_W'(16000);
         cfg_ff.threshold_level3 <= albema_pkg::LUX_W'(8000);
         cfg_ff.threshold_level2 <= albema_pkg::LUX_W'(1600);
         cfg_ff.threshold_level1 <= albema_pkg::LUX_W'(320);
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   albema_front u_front (
      .clock      (clock),
      .reset      (reset),
      .accept     (accept),
      .sample_lux (req_sample_lux),
      .beat       (front_beat)
   );

   albema_queue u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (accept),
      .push_beat (front_beat),
      .full      (q_full),
      .pop       (q_pop),
      .empty     (q_empty),
      .head_beat (head_beat)
   );

   albema_back u_back (
      .clock              (clock),
      .reset              (reset),
      .cfg                (cfg_ff),
      .q_empty            (q_empty),
      .q_head             (head_beat),
      .q_pop              (q_pop),
      .rsp_valid          (rsp_valid),
      .rsp_stall          (rsp_stall),
      .rsp_publish        (rsp_publish),
      .rsp_smoothed_lux   (rsp_smoothed_lux),
      .rsp_smoothed_valid (rsp_smoothed_valid),
      .rsp_period_average (rsp_period_average),
      .rsp_light_level    (rsp_light_level)
   );

`ifndef SYNTH
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_publish |-> rsp_smoothed_valid)
      else $error("Publish seen before the filter was loaded.");

   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_publish |-> rsp_period_average == '0)
      else $error("Period average is nonzero outside a publish.");

   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_smoothed_valid |-> rsp_smoothed_lux == '0 && rsp_light_level == '0)
      else $error("Filter output is nonzero before the filter was loaded.");

   assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> rsp_light_level <= albema_pkg::LEVEL_4)
      else $error("Light level is out of range.");
`endif

endmodule
